>>> rtl/impq_pkg.sv
// types, constants and ordering helper shared by the indexed priority queue
`default_nettype none
package impq_pkg;

	localparam int CAPACITY  = 64;
	localparam int KEY_SPACE = 1024;
	localparam int KEY_W     = 10;
	localparam int PRIO_W    = 32;
	localparam int IDX_W     = 6;
	localparam int CNT_W     = 7;

	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]         key;
		logic signed [PRIO_W-1:0] prio;
	} ent_t;

	typedef struct packed {
		logic             present;
		logic [IDX_W-1:0] slot;
	} slot_ent_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD_SLOT, S_RD_Q, S_POP_TOP, S_POP_LAST, S_UP_ST, S_UP_W,
		S_DN_ST, S_DN_L, S_DN_R, S_PLACE, S_DONE
	} state_t;

	// a sits above b: higher priority, ties to the lower key
	function automatic logic above(input ent_t a, input ent_t b);
		logic r;
		if (a.prio != b.prio)
			r = ($signed(a.prio) > $signed(b.prio));
		else
			r = (a.key < b.key);
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/impq_slot_table.sv
// key-to-slot table memory with a clearing sweep after reset
`default_nettype none
module impq_slot_table (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [impq_pkg::KEY_W-1:0] rd_addr,
	output impq_pkg::slot_ent_t           rd_data,
	input  wire logic                     we,
	input  wire logic [impq_pkg::KEY_W-1:0] wr_addr,
	input  wire impq_pkg::slot_ent_t      wr_data,
	output logic                          busy
);
	import impq_pkg::*;

	slot_ent_t        mem [KEY_SPACE];
	slot_ent_t        rd_q;
	logic             clr_q;
	logic [KEY_W-1:0] clr_idx_q;

	// sweep every entry to not present, one a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + KEY_W'(1);
			if (clr_idx_q == KEY_W'(KEY_SPACE - 1))
				clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q)
			mem[clr_idx_q] <= '0;
		else if (we)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;
	assign busy    = clr_q;

endmodule
`default_nettype wire

>>> rtl/indexed_max_priority_queue_core.sv
// top level of the indexed max-priority queue: heap memory, sift sequencer, output register
// operations: pop on empty or unused action goes straight to the result; push and query read the
// key table, a query hit then reads its heap slot; push climbs the heap level by level and an
// update may then sink; pop of the last entry ends at once, else the last entry sinks from the root
// one beat at a time: no new beat is taken until the result is registered; one heap read per step
// reset: asynchronous, active low; the key table then clears all 1024 entries, taking no beat
`default_nettype none
module indexed_max_priority_queue_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // action[1:0], key_in[11:2], priority_in[43:12], zeros
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata    // key_out[9:0], priority_out[41:10], status[43:42],
	                                    // count_out[50:44], empty_out[51], zeros
);
	import impq_pkg::*;

	state_t state_q, state_d;

	// input beat fields
	logic [1:0]        s_action;
	logic [KEY_W-1:0]  s_key;
	logic [PRIO_W-1:0] s_prio;
	assign s_action = s_tdata[1:0];
	assign s_key    = s_tdata[11:2];
	assign s_prio   = s_tdata[43:12];

	// operation context
	logic [1:0]       act_q;
	ent_t             elem_q;    // the entry being moved, held out of the heap
	ent_t             left_q;    // left child during a sink step
	logic [IDX_W-1:0] i_q;       // current hole in the heap
	logic             upd_q;     // priority change of a present key
	logic             moved_q;   // the entry climbed at least one level
	logic [CNT_W-1:0] count_q;

	// result held until the output register is free
	logic [KEY_W-1:0]  res_key_q;
	logic [PRIO_W-1:0] res_prio_q;
	logic [1:0]        res_st_q;

	logic        m_tvalid_q;
	logic [55:0] m_tdata_q;

	// heap memory
	ent_t             heap_mem [CAPACITY];
	ent_t             heap_rd;
	logic             heap_we;
	logic [IDX_W-1:0] heap_wa, heap_ra;
	ent_t             heap_wd;

	// key table
	slot_ent_t        slot_rd, slot_wd;
	logic             slot_we, clr_busy;
	logic [KEY_W-1:0] slot_wa;

	// heap index arithmetic
	logic [IDX_W-1:0] pidx;
	logic [CNT_W-1:0] lidx;
	logic [CNT_W:0]   ridx;
	logic             l_ok, r_ok;
	ent_t             best_ent;
	logic [IDX_W-1:0] best_idx;
	logic             up_go, dn_go, out_free, s_fire;

	assign pidx = (i_q - IDX_W'(1)) >> 1;
	assign lidx = {i_q, 1'b1};
	assign ridx = {1'b0, lidx} + (CNT_W+1)'(1);
	assign l_ok = (lidx < count_q);
	assign r_ok = (ridx < {1'b0, count_q});

	// larger child; the right one only exists in the second read state
	always_comb begin
		if (state_q == S_DN_R && above(heap_rd, left_q)) begin
			best_ent = heap_rd;
			best_idx = ridx[IDX_W-1:0];
		end else if (state_q == S_DN_R) begin
			best_ent = left_q;
			best_idx = lidx[IDX_W-1:0];
		end else begin
			best_ent = heap_rd;
			best_idx = lidx[IDX_W-1:0];
		end
	end

	assign up_go    = above(elem_q, heap_rd);
	assign dn_go    = above(best_ent, elem_q) &&
	                  (state_q == S_DN_R || (state_q == S_DN_L && !r_ok));
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && !clr_busy;
	assign s_fire   = s_tvalid && s_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_fire) begin
					case (s_action) inside
						ACT_POP:             state_d = (count_q == '0) ? S_DONE : S_POP_TOP;
						ACT_PUSH, ACT_QUERY: state_d = S_RD_SLOT;
						default:             state_d = S_DONE;
					endcase
				end
			end
			S_RD_SLOT: begin
				if (act_q == ACT_PUSH)
					state_d = (!slot_rd.present && count_q == CNT_W'(CAPACITY)) ?
					          S_DONE : S_UP_ST;
				else
					state_d = slot_rd.present ? S_RD_Q : S_DONE;
			end
			S_RD_Q:     state_d = S_DONE;
			S_POP_TOP:  state_d = (count_q == CNT_W'(1)) ? S_DONE : S_POP_LAST;
			S_POP_LAST: state_d = S_DN_ST;
			S_UP_ST: begin
				if (i_q != '0)
					state_d = S_UP_W;
				else
					state_d = (upd_q && !moved_q) ? S_DN_ST : S_PLACE;
			end
			S_UP_W: begin
				if (up_go)
					state_d = S_UP_ST;
				else
					state_d = (upd_q && !moved_q) ? S_DN_ST : S_PLACE;
			end
			S_DN_ST: state_d = l_ok ? S_DN_L : S_PLACE;
			S_DN_L: begin
				if (r_ok)
					state_d = S_DN_R;
				else
					state_d = dn_go ? S_DN_ST : S_PLACE;
			end
			S_DN_R:  state_d = dn_go ? S_DN_ST : S_PLACE;
			S_PLACE: state_d = S_DONE;
			S_DONE:  state_d = out_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		heap_we = 1'b0;
		heap_wa = i_q;
		heap_wd = elem_q;
		heap_ra = '0;
		slot_we = 1'b0;
		slot_wa = elem_q.key;
		slot_wd = '{present: 1'b1, slot: i_q};
		unique case (state_q)
			S_RD_SLOT: heap_ra = slot_rd.slot;
			S_POP_TOP: begin
				heap_ra = IDX_W'(count_q - CNT_W'(1));
				slot_we = 1'b1;
				slot_wa = heap_rd.key;
				slot_wd = '0;
			end
			S_UP_ST: heap_ra = pidx;
			S_UP_W: begin
				// parent drops into the hole
				if (up_go) begin
					heap_we = 1'b1;
					heap_wd = heap_rd;
					slot_we = 1'b1;
					slot_wa = heap_rd.key;
				end
			end
			S_DN_ST: heap_ra = lidx[IDX_W-1:0];
			S_DN_L, S_DN_R: begin
				if (state_q == S_DN_L)
					heap_ra = ridx[IDX_W-1:0];
				// larger child rises into the hole
				if (dn_go) begin
					heap_we = 1'b1;
					heap_wd = best_ent;
					slot_we = 1'b1;
					slot_wa = best_ent.key;
				end
			end
			S_PLACE: begin
				heap_we = 1'b1;
				slot_we = 1'b1;
			end
			default: heap_ra = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (heap_we)
			heap_mem[heap_wa] <= heap_wd;
		heap_rd <= heap_mem[heap_ra];
	end

	impq_slot_table u_slot (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (s_key),
		.rd_data (slot_rd),
		.we      (slot_we),
		.wr_addr (slot_wa),
		.wr_data (slot_wd),
		.busy    (clr_busy)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RD_SLOT && act_q == ACT_PUSH && !slot_rd.present &&
			    count_q != CNT_W'(CAPACITY))
				count_q <= count_q + CNT_W'(1);
			else if (state_q == S_POP_TOP)
				count_q <= count_q - CNT_W'(1);
			if (state_q == S_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// operation payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q      <= s_action;
				elem_q     <= '{key: s_key, prio: s_prio};
				res_key_q  <= (s_action == ACT_POP) ? '0 : s_key;
				res_prio_q <= '0;
				res_st_q   <= (s_action == ACT_POP && count_q == '0) ? ST_EMPTY : ST_OK;
				upd_q      <= 1'b0;
				moved_q    <= 1'b0;
			end
			S_RD_SLOT: begin
				if (act_q == ACT_PUSH) begin
					if (slot_rd.present) begin
						i_q        <= slot_rd.slot;
						upd_q      <= 1'b1;
						res_prio_q <= elem_q.prio;
					end else if (count_q == CNT_W'(CAPACITY)) begin
						res_st_q <= ST_FULL;
					end else begin
						i_q        <= count_q[IDX_W-1:0];
						res_prio_q <= elem_q.prio;
					end
				end else if (!slot_rd.present) begin
					res_st_q <= ST_NOTFOUND;
				end
			end
			S_RD_Q: res_prio_q <= heap_rd.prio;
			S_POP_TOP: begin
				res_key_q  <= heap_rd.key;
				res_prio_q <= heap_rd.prio;
			end
			S_POP_LAST: begin
				elem_q <= heap_rd;
				i_q    <= '0;
			end
			S_UP_W: begin
				if (up_go) begin
					i_q     <= pidx;
					moved_q <= 1'b1;
				end
			end
			S_DN_L, S_DN_R: begin
				if (state_q == S_DN_L)
					left_q <= heap_rd;
				if (dn_go)
					i_q <= best_idx;
			end
			default: ;
		endcase
		if (state_q == S_DONE && out_free)
			m_tdata_q <= {4'd0, (count_q == '0), count_q, res_st_q, res_prio_q, res_key_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// occupancy never exceeds the heap size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// no beat is taken while the key table is being cleared
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s_tready)
		else $error("input taken during table clear");

	// heap writes stay inside the occupied region
	a_heap_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		heap_we |-> ({1'b0, heap_wa} < count_q))
		else $error("heap write outside occupied slots");

	// a result appears only after the finishing state
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside finishing state");

endmodule
`default_nettype wire

>>> dv/indexed_max_priority_queue_core_tb.sv
// testbench for the indexed max-priority queue core: directed and random stream traffic
`timescale 1ns / 1ps
`default_nettype none
module indexed_max_priority_queue_core_tb;
	import impq_pkg::*;

	typedef struct packed {
		logic [1:0]  action;
		logic [9:0]  key;
		logic [31:0] prio;
	} req_t;

	// laid out as on m_tdata, first field in the top bits
	typedef struct packed {
		logic        empty;
		logic [6:0]  count;
		logic [1:0]  status;
		logic [31:0] prio;
		logic [9:0]  key;
	} rsp_t;

	localparam logic [1:0] ACT_NOP = 2'd3;
	localparam longint CYCLE_LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;

	always #5 clk = ~clk;

	indexed_max_priority_queue_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// shadow heap kept in plain arrays
	logic [9:0]  hk [CAPACITY];
	logic [31:0] hp [CAPACITY];
	int          slot_tab [KEY_SPACE];
	bit          here [KEY_SPACE];
	int          fill = 0;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int   mismatches = 0;
	int   beats_out = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   hold_off = 0;
	longint cycles = 0;
	int   n_full = 0, n_empty = 0, n_miss = 0;

	function automatic bit outranks(int a, int b);
		if (hp[a] != hp[b]) return $signed(hp[a]) > $signed(hp[b]);
		return hk[a] < hk[b];
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [9:0]  k;
		logic [31:0] p;
		k = hk[a]; p = hp[a];
		hk[a] = hk[b]; hp[a] = hp[b];
		hk[b] = k; hp[b] = p;
		slot_tab[hk[a]] = a;
		slot_tab[hk[b]] = b;
	endfunction

	function automatic void climb(int i);
		int up;
		while (i > 0) begin
			up = (i - 1) / 2;
			if (!outranks(i, up)) break;
			swap_slots(i, up);
			i = up;
		end
	endfunction

	function automatic void sink(int i);
		int best, l;
		forever begin
			best = i;
			l = 2 * i + 1;
			if (l < fill && outranks(l, best)) best = l;
			if (l + 1 < fill && outranks(l + 1, best)) best = l + 1;
			if (best == i) break;
			swap_slots(i, best);
			i = best;
		end
	endfunction

	// works out the result of one accepted request and updates the shadow heap
	function automatic rsp_t heap_outcome(req_t r);
		rsp_t o;
		int   s;
		o.key = r.key; o.prio = '0; o.status = ST_OK;
		case (r.action)
			ACT_PUSH: begin
				if (here[r.key]) begin
					s = slot_tab[r.key];
					hp[s] = r.prio;
					climb(s);
					sink(slot_tab[r.key]);
					o.prio = r.prio;
				end else if (fill >= CAPACITY) begin
					o.status = ST_FULL;
				end else begin
					hk[fill] = r.key; hp[fill] = r.prio;
					slot_tab[r.key] = fill; here[r.key] = 1'b1;
					fill++;
					climb(fill - 1);
					o.prio = r.prio;
				end
			end
			ACT_POP: begin
				o.key = '0;
				if (fill == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.key = hk[0]; o.prio = hp[0];
					here[hk[0]] = 1'b0;
					if (fill > 1) begin
						hk[0] = hk[fill-1]; hp[0] = hp[fill-1];
						slot_tab[hk[0]] = 0;
					end
					fill--;
					if (fill > 0) sink(0);
				end
			end
			ACT_QUERY: begin
				if (here[r.key]) o.prio = hp[slot_tab[r.key]];
				else o.status = ST_NOTFOUND;
			end
			default: ;
		endcase
		o.count = fill[6:0];
		o.empty = (fill == 0);
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at beat %0d: %s got %0h expected %0h", beats_out, what, got, want);
		mismatches++;
	endtask

	// driver: hold the beat until taken, then pull the next one from the queue
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					req_t r;
					rsp_t e;
					r = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, r.prio, r.key, r.action};
					e = heap_outcome(r);
					expected_rsps = {expected_rsps, e};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver hold-off countdown
	always @(posedge clk) begin
		if (hold_off > 0)
			hold_off <= hold_off - 1;
	end

	// monitor: check each result beat against the oldest expectation
	always @(posedge clk) begin
		rsp_t g, w;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end else begin
			if (m_tvalid && m_tready) begin
				g = m_tdata[51:0];
				beats_out++;
				if (expected_rsps.size() == 0) begin
					report_mismatch("unexpected beat", 32'(g.key), 32'd0);
				end else begin
					w = expected_rsps.pop_front();
					if (g.key != w.key)
						report_mismatch("key_out", 32'(g.key), 32'(w.key));
					if (g.prio != w.prio)
						report_mismatch("priority_out", g.prio, w.prio);
					if (g.status != w.status)
						report_mismatch("status", 32'(g.status), 32'(w.status));
					if (g.count != w.count)
						report_mismatch("count_out", 32'(g.count), 32'(w.count));
					if (g.empty != w.empty)
						report_mismatch("empty_out", 32'(g.empty), 32'(w.empty));
					if (w.status == ST_FULL) n_full++;
					if (w.status == ST_EMPTY) n_empty++;
					if (w.status == ST_NOTFOUND) n_miss++;
				end
			end
			if (hold_off > 0)
				m_tready <= 1'b0;
			else
				m_tready <= arst_n && ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	function automatic req_t make_req(logic [1:0] a, logic [9:0] k, logic [31:0] p);
		req_t r;
		r.action = a; r.key = k; r.prio = p;
		return r;
	endfunction

	task automatic queue_req(req_t r);
		pending_reqs = {pending_reqs, r};
	endtask

	// random priority drawn from a small set so ties happen, or fully random
	function automatic logic [31:0] rand_prio();
		case ($urandom_range(3, 0))
			0: return $urandom_range(3, 0) << 16;
			1: return {$urandom_range(1, 0) ? 1'b1 : 1'b0, 31'h0} ^ $urandom_range(2, 0);
			default: return $urandom;
		endcase
	endfunction

	task automatic drain();
		wait (pending_reqs.size() == 0 && !s_tvalid && expected_rsps.size() == 0);
		@(posedge clk);
	endtask

	task automatic random_burst(int n, int key_span);
		int pick;
		repeat (n) begin
			pick = $urandom_range(9, 0);
			if (pick < 5)
				queue_req(make_req(ACT_PUSH, 10'($urandom_range(key_span, 0)), rand_prio()));
			else if (pick < 8)
				queue_req(make_req(ACT_POP, 10'($urandom), $urandom));
			else if (pick < 9)
				queue_req(make_req(ACT_QUERY, 10'($urandom_range(key_span, 0)), $urandom));
			else
				queue_req(make_req(ACT_NOP, 10'($urandom), $urandom));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty pop, extremes, ties, update, query miss, unused action
		queue_req(make_req(ACT_POP, 10'h3FF, 32'hFFFF_FFFF));
		queue_req(make_req(ACT_QUERY, 10'd5, 32'h0));
		queue_req(make_req(ACT_PUSH, 10'd0, 32'h8000_0000));
		queue_req(make_req(ACT_PUSH, 10'h3FF, 32'h7FFF_FFFF));
		queue_req(make_req(ACT_PUSH, 10'd7, 32'h0001_0000));
		queue_req(make_req(ACT_PUSH, 10'd3, 32'h0001_0000));
		queue_req(make_req(ACT_QUERY, 10'h3FF, 32'h0));
		queue_req(make_req(ACT_PUSH, 10'h3FF, 32'hFFFF_0000));
		queue_req(make_req(ACT_PUSH, 10'd0, 32'h7FFF_FFFF));
		queue_req(make_req(ACT_NOP, 10'h2AA, 32'h5555_AAAA));
		repeat (5) queue_req(make_req(ACT_POP, 10'd0, 32'h0));
		drain();

		// fill to capacity, then a new key is refused while an update is allowed
		for (int i = 0; i < CAPACITY; i++)
			queue_req(make_req(ACT_PUSH, 10'(i * 16 + 1), rand_prio()));
		queue_req(make_req(ACT_PUSH, 10'd2, 32'h1234_5678));
		queue_req(make_req(ACT_PUSH, 10'd17, 32'h8000_0001));
		queue_req(make_req(ACT_QUERY, 10'd17, 32'h0));
		// long receiver hold-off while the sender keeps offering
		hold_off = 400;
		random_burst(20, 1023);
		drain();

		send_idle_pct = 0; recv_stall_pct = 0;   random_burst(175, 80);  drain();
		send_idle_pct = 85; recv_stall_pct = 0;  random_burst(175, 80);  drain();
		send_idle_pct = 0; recv_stall_pct = 85;  random_burst(175, 1023); drain();
		send_idle_pct = 21; recv_stall_pct = 21; random_burst(175, 80);  drain();
		repeat (200) @(posedge clk);

		$display("covered %0d result beats: %0d full refusals, %0d empty pops, %0d query misses",
			beats_out, n_full, n_empty, n_miss);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire

>>> filelist.f
rtl/impq_pkg.sv
rtl/impq_slot_table.sv
rtl/indexed_max_priority_queue_core.sv
dv/indexed_max_priority_queue_core_tb.sv
